// ===== sv/nbrq_pkg.sv =====
package nbrq_pkg;

    localparam int WORD_W  = 9;
    localparam int FILL_W  = 6;

    typedef enum logic [1:0] {
        ACT_RECEIVE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_FLUSH   = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0] action;
        logic       mode_bit;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic              empty_flag;
        logic [WORD_W-1:0] word_out;
        logic              overflow_flag;
        logic [FILL_W-1:0] fill_level;
    } out_item_t;

    // Control broadcast to every cell of the queue chain.
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [WORD_W-1:0] word;
    } cell_ctrl_t;

endpackage

// ===== sv/nbrq_cell.sv =====
module nbrq_cell #(
    parameter int IDX_W      = 5,
    parameter int CELL_INDEX = 0
) (
    input  logic                        aclk,
    input  nbrq_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [nbrq_pkg::WORD_W-1:0] neighbor_word,
    output logic [nbrq_pkg::WORD_W-1:0] word
);
    import nbrq_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              hit;

    assign hit = ctrl.load && (wr_idx == IDX_W'(CELL_INDEX));

    always_comb begin
        word_next = word_reg;
        if (hit) begin
            word_next = ctrl.word;
        end else if (ctrl.shift) begin
            word_next = neighbor_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== sv/nbrq_chain.sv =====
module nbrq_chain #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                        aclk,
    input  nbrq_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]            wr_idx,
    output logic [nbrq_pkg::WORD_W-1:0] head_word
);
    import nbrq_pkg::*;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] feed_word [DEPTH];

    // Oldest word sits in cell 0; a dequeue moves every cell one step toward it.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign feed_word[i] = '0;
        end else begin : g_mid
            assign feed_word[i] = cell_word[i+1];
        end

        nbrq_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .wr_idx        (wr_idx),
            .neighbor_word (feed_word[i]),
            .word          (cell_word[i])
        );
    end

    assign head_word = cell_word[0];

endmodule

// ===== sv/nine_bit_receive_ring_queue_top.sv =====
// Channel   Direction  Ports                       Payload
// input     in         s_valid, s_ready, s_item    nbrq_pkg::in_item_t
// result    out        m_valid, m_ready, m_item    nbrq_pkg::out_item_t
//
// One transaction per cycle: a receive writes one cell picked by the fill count,
// a dequeue shifts all cells, and the result lands in a single output register.
// A new transaction is taken while the output register is empty or being drained.
// Reset clears the fill count and the output valid; cell contents stay undefined.
// A stall on m_ready holds the result and stalls the input side.
module nine_bit_receive_ring_queue_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nbrq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output nbrq_pkg::out_item_t m_item
);
    import nbrq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_item_reg;
    out_item_t        m_item_next;

    logic              accept;
    logic              full;
    logic              empty;
    cell_ctrl_t        ctrl;
    logic [IDX_W-1:0]  wr_idx;
    logic [WORD_W-1:0] head_word;
    out_item_t         result;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctrl          = '0;
        ctrl.word     = {s_item.mode_bit, s_item.data_byte};
        wr_idx        = count_reg[IDX_W-1:0];
        count_next    = count_reg;
        result        = '0;
        case (s_item.action)
            ACT_RECEIVE: begin
                ctrl.load = accept;
                if (full) begin
                    // restart holding only the new word
                    wr_idx               = '0;
                    count_next           = CNT_W'(1);
                    result.overflow_flag = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DEQUEUE: begin
                if (empty) begin
                    result.empty_flag = 1'b1;
                end else begin
                    ctrl.shift      = accept;
                    result.word_out = head_word;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            ACT_FLUSH: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        result.fill_level = FILL_W'(count_next);

        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_item_next  = result;
        end
    end

    nbrq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .wr_idx    (wr_idx),
        .head_word (head_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_overflow_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.action == ACT_RECEIVE && full)
        |=> (m_valid && m_item.overflow_flag && m_item.fill_level == FILL_W'(1)))
        else $error("receive into full queue did not restart it");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.empty_flag)
        |-> (m_item.word_out == '0 && !m_item.overflow_flag))
        else $error("empty result carries a word or overflow");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.action == ACT_DEQUEUE && empty) |=> (count_reg == '0))
        else $error("dequeue from empty queue changed the count");

endmodule
